FILE: rtl/eccr_pkg.sv
package eccr_pkg;

	// Sizes
	localparam int MAX_IN_WIDTH  = 4096;
	localparam int ADDR_W        = 12;
	localparam int MAX_OUT_WIDTH = 8192;
	localparam int PIXEL_BITS    = 16;
	localparam int ITERS         = 28;
	localparam int ITER_W        = 5;
	localparam int ANG_W         = 34;
	localparam int CW            = 56;
	localparam int DIV_NW        = 50;
	localparam int DIV_DW        = 34;

	// Fixed-point constants (angles signed Q4.30, distances Q13.8)
	localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic [20:0]             EARTH_Q8    = 21'd1630976;

	// Half view angle: swath * 2^30 / (32 * 6371), split so that only a
	// 32-bit quotient by 6371 is left, done by reciprocal multiply
	localparam logic [12:0] EARTH_KM = 13'd6371;
	localparam logic [12:0] HQ_INT   = 13'd5266;   // floor(2^25 / 6371)
	localparam logic [12:0] HQ_FRAC  = 13'd4746;   // 2^25 mod 6371
	localparam logic [11:0] HQ_BIAS  = 12'd3185;   // rounding term over 32
	localparam logic [19:0] KM_RECIP = 20'd674143; // floor(2^32 / 6371)

	// Register indexes
	localparam logic [1:0] REG_SAT_HEIGHT = 2'd0;
	localparam logic [1:0] REG_SWATH      = 2'd1;
	localparam logic [1:0] REG_RESOLUTION = 2'd2;
	localparam logic [1:0] REG_IN_WIDTH   = 2'd3;

	// Opcodes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// CORDIC modes
	localparam logic MODE_ROTATE = 1'b0;
	localparam logic MODE_VECTOR = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [12:0] column;
		logic [15:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic [11:0] source_column;
		logic        out_of_range;
	} rsp_t;

	typedef struct packed {
		logic                    go;
		logic                    mode;
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] z;
	} crd_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] z;
	} crd_rsp_t;

	// Elementary angle of CORDIC step k
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [ITER_W-1:0] k);
		logic signed [ANG_W-1:0] r;
		begin
			case (k)
				5'd0: r = 34'sd843314857;
				5'd1: r = 34'sd497837829;
				5'd2: r = 34'sd263043837;
				5'd3: r = 34'sd133525159;
				5'd4: r = 34'sd67021687;
				5'd5: r = 34'sd33543516;
				5'd6: r = 34'sd16775851;
				5'd7: r = 34'sd8388437;
				5'd8: r = 34'sd4194283;
				5'd9: r = 34'sd2097149;
				default: r = 34'sd1 <<< (5'd30 - k);
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/eccr_ram.sv
module eccr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/eccr_div.sv
module eccr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [eccr_pkg::DIV_NW-1:0]  num,
	input  logic [eccr_pkg::DIV_DW-1:0]  den,
	output logic                         done,
	output logic [eccr_pkg::DIV_NW-1:0]  quo
);

	logic                         run_q;
	logic                         done_q;
	logic [5:0]                   cnt_q;
	logic [eccr_pkg::DIV_NW-1:0]  nq_q;
	logic [eccr_pkg::DIV_DW-1:0]  rem_q;
	logic [eccr_pkg::DIV_DW-1:0]  den_q;
	logic [eccr_pkg::DIV_DW:0]    shifted;
	logic [eccr_pkg::DIV_DW+1:0]  trial;
	logic                         qbit;
	logic [eccr_pkg::DIV_DW-1:0]  rem_nx;

	// One restoring step: shift in next numerator bit, trial subtract
	always_comb begin
		shifted = {rem_q, nq_q[eccr_pkg::DIV_NW-1]};
		trial   = {1'b0, shifted} - {2'b0, den_q};
		qbit    = ~trial[eccr_pkg::DIV_DW+1];
		rem_nx  = qbit ? trial[eccr_pkg::DIV_DW-1:0] : shifted[eccr_pkg::DIV_DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(eccr_pkg::DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Numerator register fills with quotient bits as it empties
	always_ff @(posedge clk) begin
		if (go) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			nq_q  <= {nq_q[eccr_pkg::DIV_NW-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

FILE: rtl/eccr_cordic.sv
module eccr_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  eccr_pkg::crd_req_t req,
	output eccr_pkg::crd_rsp_t rsp
);

	logic                                  run_q;
	logic                                  done_q;
	logic                                  mode_q;
	logic [eccr_pkg::ITER_W-1:0]           k_q;
	logic signed [eccr_pkg::CW-1:0]        x_q;
	logic signed [eccr_pkg::CW-1:0]        y_q;
	logic signed [eccr_pkg::ANG_W-1:0]     z_q;
	logic signed [eccr_pkg::CW-1:0]        dx;
	logic signed [eccr_pkg::CW-1:0]        dy;
	logic signed [eccr_pkg::ANG_W-1:0]     at;
	logic                                  dpos;

	// One micro-rotation per cycle; rotation drives z to 0, vectoring drives y to 0
	always_comb begin
		dx   = y_q >>> k_q;
		dy   = x_q >>> k_q;
		at   = eccr_pkg::atan_step(k_q);
		dpos = (mode_q == eccr_pkg::MODE_ROTATE) ? (z_q >= 0) : (y_q < 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 5'd1;
				if (k_q == 5'(eccr_pkg::ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			mode_q <= req.mode;
			x_q    <= req.x;
			y_q    <= req.y;
			z_q    <= req.z;
		end else if (run_q) begin
			if (dpos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;

endmodule

FILE: rtl/earth_curvature_column_remap_top.sv
// Store transactions (opcode 0) write one pixel into the 4096-entry line buffer if the
// column is below 4096; busy stays low, so stores can be issued every cycle while no fetch
// is running. A fetch transaction (opcode 1) raises busy until its result is out: one
// shared 50-step restoring divider, one shared 28-step CORDIC unit and a reciprocal
// multiply for the half view angle set the latency. An out-of-range fetch ends after its
// first division; a full fetch uses three divisions and four CORDIC passes plus memory
// read (the third division is skipped when the edge angle is not positive).
// Each result is shown for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle. A new transaction may start in the cycle done is high.
module earth_curvature_column_remap_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  eccr_pkg::req_t      req,
	output logic                done,
	output eccr_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CW_GO  = 5'd1;
	localparam logic [4:0] ST_CW_WT  = 5'd2;
	localparam logic [4:0] ST_HQ_GO  = 5'd3;
	localparam logic [4:0] ST_HQ_WT  = 5'd4;
	localparam logic [4:0] ST_AM     = 5'd5;
	localparam logic [4:0] ST_AD_GO  = 5'd6;
	localparam logic [4:0] ST_AD_WT  = 5'd7;
	localparam logic [4:0] ST_ROT_GO = 5'd8;
	localparam logic [4:0] ST_ROT_WT = 5'd9;
	localparam logic [4:0] ST_PROD   = 5'd10;
	localparam logic [4:0] ST_VEC_GO = 5'd11;
	localparam logic [4:0] ST_VEC_WT = 5'd12;
	localparam logic [4:0] ST_SM     = 5'd13;
	localparam logic [4:0] ST_SD_GO  = 5'd14;
	localparam logic [4:0] ST_SD_WT  = 5'd15;
	localparam logic [4:0] ST_RD     = 5'd16;
	localparam logic [4:0] ST_OUT    = 5'd17;
	localparam logic [4:0] ST_HQ_FIX = 5'd18;

	localparam int AW = eccr_pkg::ANG_W;

	// Configuration
	logic [19:0] hgt_q;
	logic [18:0] swath_q;
	logic [15:0] res_q;
	logic [12:0] width_q;

	// Control and datapath registers
	logic [4:0]                state_q;
	logic                      done_q;
	eccr_pkg::rsp_t            rsp_q;
	logic [12:0]               col_q;
	logic [13:0]               cw_q;
	logic [30:0]               hq_q;
	logic [31:0]               hq_t_q;
	logic [31:0]               hq_base_q;
	logic [18:0]               hq_est_q;
	logic                      neg_q;
	logic [44:0]               prod_q;
	logic signed [AW-1:0]      a_q;
	logic                      second_q;
	logic                      flip_q;
	logic signed [AW-1:0]      sin_q;
	logic signed [AW-1:0]      cos_q;
	logic signed [26:0]        vx_q;
	logic signed [26:0]        vy_q;
	logic signed [AW-1:0]      edge_q;
	logic signed [AW-1:0]      ang_q;
	logic [11:0]               src_q;

	// Effective configuration values
	logic [15:0] res_eff;
	logic [12:0] width_eff;

	always_comb begin
		res_eff   = (res_q == 16'd0) ? 16'd1 : res_q;
		if (width_q == 13'd0) begin
			width_eff = 13'd1;
		end else if (width_q > 13'(eccr_pkg::MAX_IN_WIDTH)) begin
			width_eff = 13'(eccr_pkg::MAX_IN_WIDTH);
		end else begin
			width_eff = width_q;
		end
	end

	// Transaction accept
	logic accept;
	logic ram_we;
	assign accept = start && !busy;
	assign ram_we = accept && (req.opcode == eccr_pkg::OP_STORE) && !req.column[12];

	// Line buffer
	logic [15:0] ram_rdata;
	eccr_ram #(
		.WIDTH(eccr_pkg::PIXEL_BITS),
		.DEPTH(eccr_pkg::MAX_IN_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.column[eccr_pkg::ADDR_W-1:0]),
		.wdata (req.pixel_in),
		.re    (state_q == ST_RD),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	// Shared divider operand select
	logic                         div_go;
	logic [eccr_pkg::DIV_NW-1:0]  div_num;
	logic [eccr_pkg::DIV_DW-1:0]  div_den;
	logic                         div_done;
	logic [eccr_pkg::DIV_NW-1:0]  div_quo;

	always_comb begin
		div_go  = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			ST_CW_GO: begin
				div_go  = 1'b1;
				div_num = eccr_pkg::DIV_NW'({swath_q, 5'b0}) + eccr_pkg::DIV_NW'(res_eff);
				div_den = eccr_pkg::DIV_DW'({res_eff, 1'b0});
			end
			ST_AD_GO: begin
				div_go  = 1'b1;
				div_num = eccr_pkg::DIV_NW'(prod_q);
				div_den = eccr_pkg::DIV_DW'(cw_q);
			end
			ST_SD_GO: begin
				div_go  = 1'b1;
				div_num = eccr_pkg::DIV_NW'(prod_q);
				div_den = {edge_q[AW-2:0], 1'b0};
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	eccr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// CORDIC request: fold the angle into +-pi/2 for rotation
	logic signed [AW-1:0] rot_in;
	logic signed [AW-1:0] rot_z;
	logic                 rot_flip;
	eccr_pkg::crd_req_t   crd_req;
	eccr_pkg::crd_rsp_t   crd_rsp;

	always_comb begin
		rot_in   = second_q ? a_q : $signed({3'b0, hq_q});
		rot_flip = 1'b0;
		rot_z    = rot_in;
		if (rot_in > eccr_pkg::HALF_PI_Q30) begin
			rot_z    = rot_in - eccr_pkg::PI_Q30;
			rot_flip = 1'b1;
		end else if (rot_in < -eccr_pkg::HALF_PI_Q30) begin
			rot_z    = rot_in + eccr_pkg::PI_Q30;
			rot_flip = 1'b1;
		end
		crd_req.go   = (state_q == ST_ROT_GO) || (state_q == ST_VEC_GO);
		crd_req.mode = (state_q == ST_VEC_GO) ? eccr_pkg::MODE_VECTOR : eccr_pkg::MODE_ROTATE;
		if (state_q == ST_VEC_GO) begin
			crd_req.x = $signed(eccr_pkg::CW'(vx_q)) <<< 24;
			crd_req.y = $signed(eccr_pkg::CW'(vy_q)) <<< 24;
			crd_req.z = '0;
		end else begin
			crd_req.x = eccr_pkg::CW'(eccr_pkg::GAIN_Q30);
			crd_req.y = '0;
			crd_req.z = rot_z;
		end
	end

	eccr_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crd_req),
		.rsp    (crd_rsp)
	);

	// Datapath helpers
	logic [13:0]          cw_sat;
	logic [51:0]          hq_mul;
	logic [31:0]          hq_rem;
	logic [32:0]          hq_sum;
	logic [30:0]          hq_fix;
	logic [13:0]          two_col;
	logic [13:0]          diff;
	logic signed [55:0]   mul_c;
	logic signed [55:0]   mul_s;
	logic signed [26:0]   orbit;
	logic signed [26:0]   vx_nx;
	logic signed [AW:0]   num_sum;
	logic [32:0]          num_pos;
	logic [11:0]          wmax;

	always_comb begin
		cw_sat  = (div_quo > eccr_pkg::DIV_NW'(eccr_pkg::MAX_OUT_WIDTH))
			? 14'(eccr_pkg::MAX_OUT_WIDTH) : div_quo[13:0];
		// quotient estimate is exact or one low; one compare corrects it
		hq_mul  = {20'b0, hq_t_q} * {32'b0, eccr_pkg::KM_RECIP};
		hq_rem  = hq_t_q - ({13'b0, hq_est_q} * {19'b0, eccr_pkg::EARTH_KM});
		hq_sum  = {1'b0, hq_base_q} + {14'b0, hq_est_q}
			+ {32'b0, (hq_rem >= {19'b0, eccr_pkg::EARTH_KM})};
		hq_fix  = (hq_sum[32:31] != 2'b00) ? 31'h7FFFFFFF : hq_sum[30:0];
		two_col = {col_q, 1'b0};
		diff    = (two_col >= cw_q) ? (two_col - cw_q) : (cw_q - two_col);
		mul_c   = $signed({1'b0, eccr_pkg::EARTH_Q8}) * cos_q;
		mul_s   = $signed({1'b0, eccr_pkg::EARTH_Q8}) * sin_q;
		orbit   = $signed(27'(eccr_pkg::EARTH_Q8) + 27'({hgt_q, 4'b0}));
		vx_nx   = orbit - 27'(mul_c >>> 30);
		num_sum = $signed({ang_q[AW-1], ang_q}) + $signed({edge_q[AW-1], edge_q});
		num_pos = num_sum[AW] ? 33'd0 : num_sum[32:0];
		wmax    = 12'(width_eff - 13'd1);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hgt_q   <= 20'd13120;
			swath_q <= 19'd46400;
			res_q   <= 16'd282;
			width_q <= 13'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				eccr_pkg::REG_SAT_HEIGHT: hgt_q   <= cfg_data;
				eccr_pkg::REG_SWATH:      swath_q <= cfg_data[18:0];
				eccr_pkg::REG_RESOLUTION: res_q   <= cfg_data[15:0];
				eccr_pkg::REG_IN_WIDTH:   width_q <= cfg_data[12:0];
				default:                  hgt_q   <= hgt_q;
			endcase
		end
	end

	// Fetch sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.opcode == eccr_pkg::OP_FETCH)) begin
						state_q <= ST_CW_GO;
					end
				end
				ST_CW_GO:  state_q <= ST_CW_WT;
				ST_CW_WT: begin
					if (div_done) begin
						if ({1'b0, col_q} >= cw_sat) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HQ_GO;
						end
					end
				end
				ST_HQ_GO:  state_q <= ST_HQ_WT;
				ST_HQ_WT:  state_q <= ST_HQ_FIX;
				ST_HQ_FIX: state_q <= ST_AM;
				ST_AM:     state_q <= ST_AD_GO;
				ST_AD_GO:  state_q <= ST_AD_WT;
				ST_AD_WT: begin
					if (div_done) begin
						second_q <= 1'b0;
						state_q  <= ST_ROT_GO;
					end
				end
				ST_ROT_GO: state_q <= ST_ROT_WT;
				ST_ROT_WT: begin
					if (crd_rsp.done) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD:   state_q <= ST_VEC_GO;
				ST_VEC_GO: state_q <= ST_VEC_WT;
				ST_VEC_WT: begin
					if (crd_rsp.done) begin
						if (!second_q) begin
							second_q <= 1'b1;
							state_q  <= ST_ROT_GO;
						end else begin
							state_q <= ST_SM;
						end
					end
				end
				ST_SM: begin
					if (edge_q <= 0) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_SD_GO;
					end
				end
				ST_SD_GO:  state_q <= ST_SD_WT;
				ST_SD_WT: begin
					if (div_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:     state_q <= ST_OUT;
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= req.column;
			end
			ST_CW_WT: begin
				cw_q  <= cw_sat;
				rsp_q <= '{pixel_out: '0, source_column: '0, out_of_range: 1'b1};
			end
			ST_HQ_GO: begin
				hq_t_q    <= ({13'b0, swath_q} * {19'b0, eccr_pkg::HQ_FRAC})
					+ {20'b0, eccr_pkg::HQ_BIAS};
				hq_base_q <= {13'b0, swath_q} * {19'b0, eccr_pkg::HQ_INT};
			end
			ST_HQ_WT: begin
				hq_est_q <= hq_mul[50:32];
			end
			ST_HQ_FIX: begin
				hq_q <= hq_fix;
			end
			ST_AM: begin
				neg_q  <= (two_col < cw_q);
				prod_q <= 45'(diff) * 45'(hq_q);
			end
			ST_AD_WT: begin
				a_q <= neg_q ? -$signed({3'b0, div_quo[30:0]}) : $signed({3'b0, div_quo[30:0]});
			end
			ST_ROT_GO: begin
				flip_q <= rot_flip;
			end
			ST_ROT_WT: begin
				sin_q <= flip_q ? -AW'(crd_rsp.y) : AW'(crd_rsp.y);
				cos_q <= flip_q ? -AW'(crd_rsp.x) : AW'(crd_rsp.x);
			end
			ST_PROD: begin
				vx_q <= vx_nx[26] ? 27'sd0 : vx_nx;
				vy_q <= 27'(mul_s >>> 30);
			end
			ST_VEC_WT: begin
				if (!second_q) begin
					edge_q <= crd_rsp.z;
				end else begin
					ang_q <= crd_rsp.z;
				end
			end
			ST_SM: begin
				src_q  <= width_eff[12:1];
				prod_q <= 45'({12'b0, num_pos} * {32'b0, width_eff});
			end
			ST_SD_WT: begin
				src_q <= (div_quo > eccr_pkg::DIV_NW'(wmax)) ? wmax : div_quo[11:0];
			end
			ST_OUT: begin
				rsp_q <= '{pixel_out: ram_rdata, source_column: src_q, out_of_range: 1'b0};
			end
			default: begin
				col_q <= col_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_OUT) || ($past(state_q) == ST_CW_WT))
		else $error("result strobe without a finishing fetch");

	a_no_store_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy)
		else $error("line buffer written during a fetch");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.out_of_range) |-> (rsp.pixel_out == '0) && (rsp.source_column == '0))
		else $error("out-of-range result carries data");

	a_src_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.out_of_range) |-> ({1'b0, rsp.source_column} < width_eff))
		else $error("source column beyond input width");

endmodule

FILE: tb/remap_checker.sv
module remap_checker
	import eccr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        done,
	input  rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint EARTH_KM_Q8 = 1630976;
	localparam longint GAIN        = 652032874;
	localparam longint PI_A        = 64'sd3373259426;
	localparam longint HALF_PI_A   = 64'sd1686629713;

	// shadow of the register file and line buffer
	logic [19:0] height;
	logic [18:0] swath;
	logic [15:0] resol;
	logic [12:0] in_width;
	logic [15:0] line_mem [MAX_IN_WIDTH];
	rsp_t        expected_pixels [$];

	function automatic longint micro_angle(int k);
		longint tbl [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (k < 10) return tbl[k];
		return longint'(1) << (30 - k);
	endfunction

	// rotation CORDIC, folded by pi outside +-pi/2
	function automatic void rotate(input longint a, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN; y = 0; z = a; flip = 0;
		if (z > HALF_PI_A) begin
			z -= PI_A; flip = 1;
		end else if (z < -HALF_PI_A) begin
			z += PI_A; flip = 1;
		end
		for (int k = 0; k < ITERS; k++) begin
			dx = y >>> k; dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= micro_angle(k);
			end else begin
				x += dx; y -= dy; z += micro_angle(k);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// angle seen from the satellite for ground angle a
	function automatic longint look_angle(longint a, longint orbit);
		longint s, c, x, y, z, dx, dy;
		rotate(a, s, c);
		x = orbit - ((EARTH_KM_Q8 * c) >>> 30);
		y = (EARTH_KM_Q8 * s) >>> 30;
		if (x < 0) x = 0;
		x = x <<< 24; y = y <<< 24; z = 0;
		for (int k = 0; k < ITERS; k++) begin
			dx = y >>> k; dy = x >>> k;
			if (y >= 0) begin
				x += dx; y -= dy; z += micro_angle(k);
			end else begin
				x -= dx; y += dy; z -= micro_angle(k);
			end
		end
		return z;
	endfunction

	function automatic rsp_t remap_column(longint unsigned col);
		longint unsigned res, cw, wd, hq, mag, src;
		longint a, edge_ang, ang, orbit, num;
		rsp_t r;
		r = '0;
		res = (resol != 0) ? resol : 1;
		cw = (longint'(swath) * 32 + res) / (2 * res);
		if (cw > MAX_OUT_WIDTH) cw = MAX_OUT_WIDTH;
		if (col >= cw) begin
			r.out_of_range = 1'b1;
			return r;
		end
		wd = in_width;
		if (wd == 0) wd = 1;
		if (wd > MAX_IN_WIDTH) wd = MAX_IN_WIDTH;
		hq = ((longint'(swath) << 30) + 101936) / 203872;
		if (hq > 64'h7FFF_FFFF) hq = 64'h7FFF_FFFF;
		if (2 * col >= cw) begin
			mag = ((2 * col - cw) * hq) / cw;
			a = longint'(mag);
		end else begin
			mag = ((cw - 2 * col) * hq) / cw;
			a = -longint'(mag);
		end
		orbit = EARTH_KM_Q8 + longint'(height) * 16;
		edge_ang = look_angle(longint'(hq), orbit);
		ang = look_angle(a, orbit);
		if (edge_ang <= 0) begin
			src = wd / 2;
		end else begin
			num = ang + edge_ang;
			if (num < 0) num = 0;
			src = (longint'(num) * wd) / (2 * longint'(edge_ang));
		end
		if (src > wd - 1) src = wd - 1;
		r.pixel_out = line_mem[src[11:0]];
		r.source_column = src[11:0];
		return r;
	endfunction

	// track transactions, predict fetches, compare results
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		int   nerr;
		if (!arst_n) begin
			height <= 20'd13120;
			swath <= 19'd46400;
			resol <= 16'd282;
			in_width <= 13'd2048;
			errors <= 0;
			pending <= 0;
		end else begin
			nerr = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SAT_HEIGHT: height <= cfg_data;
					REG_SWATH:      swath <= cfg_data[18:0];
					REG_RESOLUTION: resol <= cfg_data[15:0];
					REG_IN_WIDTH:   in_width <= cfg_data[12:0];
					default:        height <= height;
				endcase
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$error("result with no fetch outstanding");
					nerr++;
				end else begin
					exp_r = expected_pixels.pop_front();
					if (rsp.pixel_out !== exp_r.pixel_out) begin
						$error("pixel_out exp %0d got %0d", exp_r.pixel_out, rsp.pixel_out);
						nerr++;
					end
					if (rsp.source_column !== exp_r.source_column) begin
						$error("source_column exp %0d got %0d",
							exp_r.source_column, rsp.source_column);
						nerr++;
					end
					if (rsp.out_of_range !== exp_r.out_of_range) begin
						$error("out_of_range exp %0d got %0d",
							exp_r.out_of_range, rsp.out_of_range);
						nerr++;
					end
				end
			end
			if (start && !busy) begin
				if (req.opcode == OP_STORE) begin
					if (req.column < MAX_IN_WIDTH) line_mem[req.column[11:0]] = req.pixel_in;
				end else begin
					expected_pixels.push_back(remap_column(req.column));
				end
			end
			errors <= errors + nerr;
			pending <= expected_pixels.size();
		end
	end
endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import eccr_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_SAT_HEIGHT;
	logic [19:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          stall_cycles = 0;
	int          sent = 0;

	// line buffer entries stored so far, so fetches only read written pixels
	bit          written [MAX_IN_WIDTH];

	// local copy of the swath and resolution registers, used only to aim fetch columns
	logic [18:0] sh_swath = 19'd46400;
	logic [15:0] sh_resol = 16'd282;

	earth_curvature_column_remap_top uut (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.cfg_we, .cfg_index, .cfg_data
	);

	remap_checker chk (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.cfg_we, .cfg_index, .cfg_data, .errors, .pending
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic int corr_width();
		longint res, cw;
		res = (sh_resol != 0) ? sh_resol : 1;
		cw = (longint'(sh_swath) * 32 + res) / (2 * res);
		return (cw > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(cw);
	endfunction

	// present one transaction, return at the edge that takes it or, with may_idle, after idling start
	task automatic send(input logic op, input logic [12:0] col, input logic [15:0] pix,
			input bit may_idle);
		start <= 1'b1;
		req <= '{opcode: op, column: col, pixel_in: pix};
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		sent++;
		if (op == OP_STORE && !col[12]) written[col[11:0]] = 1'b1;
		if (may_idle) begin
			while ($urandom_range(99) < 16) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// store the source pixel first when the fetch would read an unwritten entry
	task automatic fetch(input logic [12:0] col, input bit may_idle);
		rsp_t p;
		p = chk.remap_column(64'(col));
		if (!p.out_of_range && !written[p.source_column])
			send(OP_STORE, {1'b0, p.source_column}, 16'($urandom), may_idle);
		send(OP_FETCH, col, 16'($urandom), may_idle);
	endtask

	// wait for all results and a quiet block
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [19:0] h, input logic [19:0] sw,
			input logic [19:0] rs, input logic [19:0] wd);
		drain();
		cfg_we <= 1'b1; cfg_index <= REG_SAT_HEIGHT; cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_SWATH; cfg_data <= sw;
		@(posedge clk);
		cfg_index <= REG_RESOLUTION; cfg_data <= rs;
		@(posedge clk);
		cfg_index <= REG_IN_WIDTH; cfg_data <= wd;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_swath = sw[18:0];
		sh_resol = rs[15:0];
		@(posedge clk);
	endtask

	task automatic random_items(input int n, input bit may_idle);
		int cw;
		logic [12:0] col;
		for (int i = 0; i < n; i++) begin
			cw = corr_width();
			if ($urandom_range(99) < 55) begin
				send(OP_STORE, 13'($urandom), 16'($urandom), may_idle);
			end else begin
				if (cw > 0 && $urandom_range(99) < 85)
					col = 13'($urandom_range(cw - 1));
				else
					col = 13'($urandom);
				fetch(col, may_idle);
			end
		end
	endtask

	task automatic directed_fetches();
		int cw;
		cw = corr_width();
		fetch(13'd0, 0);
		fetch(13'd8191, 0);
		if (cw > 0) begin
			fetch(13'(cw - 1), 0);
			fetch(13'(cw / 2), 0);
		end
		if (cw < 8192) fetch(13'(cw), 0);
	endtask

	initial begin
		int phase_h [6] = '{20'd13120, 20'd0, 20'd1048575, 20'd1048575, 20'd500, 20'd13120};
		int phase_s [6] = '{46400, 16, 524287, 524287, 0, 46400};
		int phase_r [6] = '{282, 1, 65535, 1, 0, 282};
		int phase_w [6] = '{2048, 1, 4096, 4096, 0, 8191};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stores at the pixel extremes and beyond the buffer
		send(OP_STORE, 13'd0, 16'hFFFF, 0);
		send(OP_STORE, 13'd4095, 16'h0000, 0);
		send(OP_STORE, 13'd4096, 16'h1234, 0);
		send(OP_STORE, 13'd8191, 16'hFFFF, 0);
		directed_fetches();

		for (int p = 0; p < 8; p++) begin
			if (p < 6)
				configure(20'(phase_h[p]), 20'(phase_s[p]), 20'(phase_r[p]),
					20'(phase_w[p]));
			else
				configure(20'($urandom), 20'($urandom_range(16, 524287)),
					20'($urandom_range(1, 65535)), 20'($urandom_range(1, 4096)));
			directed_fetches();
			if (p == 2) begin
				// long run with the sender never idling
				random_items(200, 0);
			end else begin
				random_items(45, 1);
				drain();
				random_items(45, 1);
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
